### rtl/dft_magnitude_spectrum_assert.svh
// ----------------------------------------------------------------------------
// dft magnitude spectrum assertion macros
// concurrent assertion helpers used by dft_magnitude_spectrum
// ----------------------------------------------------------------------------
`ifndef DFT_MAGNITUDE_SPECTRUM_ASSERT_SVH
`define DFT_MAGNITUDE_SPECTRUM_ASSERT_SVH

// same-cycle implication
`define DFTMS_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define DFTMS_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons) \
	name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

### rtl/dftms_pkg.sv
// ----------------------------------------------------------------------------
// dftms_pkg
// widths, shared types and twiddle table construction for the dft block
// ----------------------------------------------------------------------------
package dftms_pkg;

	localparam int POINTS    = 128;
	localparam int HALF      = POINTS / 2;
	localparam int ADDR_W    = $clog2(POINTS);
	localparam int SAMPLE_W  = 16;
	localparam int TWID_W    = 16;
	localparam int PROD_W    = SAMPLE_W + TWID_W;
	localparam int ACC_W     = PROD_W + ADDR_W;
	localparam int Q8_SHIFT  = 7;
	localparam int RND_W     = ACC_W - Q8_SHIFT;
	localparam int SQ_W      = 2 * RND_W;
	localparam int BIN_W     = 6;
	localparam int MAG_W     = 24;
	localparam int TWO_N     = 2 * POINTS;

	localparam logic [63:0] C1 = 64'd1686629713;
	localparam logic [63:0] C3 = 64'd693598668;
	localparam logic [63:0] C5 = 64'd85569305;
	localparam logic [63:0] C7 = 64'd5026995;
	localparam logic [63:0] C9 = 64'd172272;

	typedef logic signed [TWID_W-1:0] twid_tab_t [POINTS];

	typedef struct packed {
		logic busy;
		logic done;
	} sqrt_stat_t;

	// quadrant sine, q in 0..16384, q1.15 result
	function automatic logic [TWID_W-1:0] quarter_sine(input logic [14:0] q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = 64'(q) << 16;
		x2 = (x * x) >> 30;
		t  = C9;
		t  = C7 - ((x2 * t) >> 30);
		t  = C5 - ((x2 * t) >> 30);
		t  = C3 - ((x2 * t) >> 30);
		t  = C1 - ((x2 * t) >> 30);
		s  = (x * t) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return s[TWID_W-1:0];
	endfunction

	function automatic logic signed [TWID_W-1:0] sine_q15(input logic [15:0] ph);
		logic [TWID_W-1:0] v;
		if (ph[14]) begin
			v = quarter_sine(15'd16384 - {1'b0, ph[13:0]});
		end else begin
			v = quarter_sine({1'b0, ph[13:0]});
		end
		return ph[15] ? $signed(-v) : $signed(v);
	endfunction

	function automatic twid_tab_t build_twiddle(input logic cos_sel);
		twid_tab_t   tab;
		longint      num;
		logic [15:0] ph;
		for (int m = 0; m < POINTS; m++) begin
			num = 64'(2 * m) * 64'd65536 + 64'(POINTS);
			ph  = 16'(num / TWO_N);
			if (cos_sel) begin
				ph = ph + 16'd16384;
			end
			tab[m] = sine_q15(ph);
		end
		return tab;
	endfunction

endpackage

### rtl/dft_magnitude_spectrum.sv
// ----------------------------------------------------------------------------
// dft_magnitude_spectrum
// frame store, shared complex mac over a twiddle rom, magnitude per bin
// ----------------------------------------------------------------------------
// channel  direction  handshake            payload
// input    in         in_valid / in_stall   sample
// output   out        out_valid / out_stall bin_index, magnitude, last_bin
//
// samples are taken one per cycle until the frame of POINTS is full
// each bin then runs a mac over the frame, a drain of the multiply pipeline,
// rounding, the square states SQA, SQB and SQC, the square root and an emit step
// in_stall is high meanwhile
// a bin waits in emit while the output register is held by out_stall
// reset clears the fill count, sequencer and output valid
// ----------------------------------------------------------------------------
`include "dft_magnitude_spectrum_assert.svh"

module dft_magnitude_spectrum (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	output logic                                 in_stall,
	input  logic signed [dftms_pkg::SAMPLE_W-1:0] sample,
	output logic                                 out_valid,
	input  logic                                 out_stall,
	output logic [dftms_pkg::BIN_W-1:0]          bin_index,
	output logic [dftms_pkg::MAG_W-1:0]          magnitude,
	output logic                                 last_bin
);
	import dftms_pkg::*;

	typedef enum logic [8:0] {
		ST_COLLECT = 9'b000000001,
		ST_MAC     = 9'b000000010,
		ST_DRAIN   = 9'b000000100,
		ST_ROUND   = 9'b000001000,
		ST_SQA     = 9'b000010000,
		ST_SQB     = 9'b000100000,
		ST_SQC     = 9'b001000000,
		ST_SQRT    = 9'b010000000,
		ST_EMIT    = 9'b100000000
	} state_t;

	localparam twid_tab_t COS_TAB = build_twiddle(1'b1);
	localparam twid_tab_t SIN_TAB = build_twiddle(1'b0);

	localparam logic [ADDR_W-1:0] FILL_LAST = ADDR_W'(POINTS - 1);
	localparam logic [BIN_W-1:0]  BIN_LAST  = BIN_W'(HALF - 1);
	localparam logic [ACC_W:0]    RND_HALF  = (ACC_W+1)'(1) << (Q8_SHIFT - 1);

	state_t                     state_q;
	logic [ADDR_W-1:0]          fill_q;
	logic [ADDR_W-1:0]          n_q;
	logic [ADDR_W-1:0]          m_q;
	logic [BIN_W-1:0]           k_q;
	logic [SAMPLE_W-1:0]        frame_mem [POINTS];

	logic signed [SAMPLE_W-1:0] samp_s1;
	logic signed [TWID_W-1:0]   cos_s1;
	logic signed [TWID_W-1:0]   sin_s1;
	logic                       v_s1;
	logic signed [PROD_W-1:0]   pre_s2;
	logic signed [PROD_W-1:0]   pim_s2;
	logic                       v_s2;
	logic signed [ACC_W-1:0]    re_q;
	logic signed [ACC_W-1:0]    im_q;

	logic [RND_W-1:0]           a_q;
	logic [RND_W-1:0]           b_q;
	logic [SQ_W-1:0]            sq_s1;
	logic [SQ_W-1:0]            sum_q;

	logic                       out_valid_q;
	logic [BIN_W-1:0]           bin_index_q;
	logic [MAG_W-1:0]           magnitude_q;
	logic                       last_bin_q;

	logic                       in_acc;
	logic                       emit_go;
	logic [ADDR_W:0]            m_sum;
	logic [ADDR_W-1:0]          m_next;
	logic [ACC_W-1:0]           abs_re;
	logic [ACC_W-1:0]           abs_im;
	logic [ACC_W:0]             rnd_re;
	logic [ACC_W:0]             rnd_im;
	logic [RND_W-1:0]           sq_op;
	logic                       sqrt_start;
	logic [SQ_W-1:0]            radicand;
	sqrt_stat_t                 sqrt_stat;
	logic [RND_W-1:0]           root;
	logic [RND_W:0]             mag_sum;
	logic [RND_W:0]             mag_div;

	assign in_stall = (state_q != ST_COLLECT);
	assign in_acc   = in_valid && !in_stall;
	assign emit_go  = (state_q == ST_EMIT) && (!out_valid_q || !out_stall);

	// phase index steps by k modulo the frame length
	assign m_sum  = {1'b0, m_q} + (ADDR_W+1)'(k_q);
	assign m_next = (m_sum >= (ADDR_W+1)'(POINTS)) ?
		ADDR_W'(m_sum - (ADDR_W+1)'(POINTS)) : m_sum[ADDR_W-1:0];

	assign abs_re = re_q[ACC_W-1] ? ACC_W'(-re_q) : ACC_W'(re_q);
	assign abs_im = im_q[ACC_W-1] ? ACC_W'(-im_q) : ACC_W'(im_q);
	assign rnd_re = {1'b0, abs_re} + RND_HALF;
	assign rnd_im = {1'b0, abs_im} + RND_HALF;

	assign sq_op      = (state_q == ST_SQA) ? a_q : b_q;
	assign sqrt_start = (state_q == ST_SQC);
	assign radicand   = sum_q + sq_s1;

	assign mag_sum = {1'b0, root} + (RND_W+1)'(HALF);
	assign mag_div = mag_sum / (RND_W+1)'(POINTS);

	dftms_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (radicand),
		.stat     (sqrt_stat),
		.root     (root)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_COLLECT;
			fill_q  <= '0;
			n_q     <= '0;
			m_q     <= '0;
			k_q     <= '0;
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
		end else begin
			v_s1 <= (state_q == ST_MAC);
			v_s2 <= v_s1;
			case (state_q)
				ST_COLLECT: begin
					if (in_acc) begin
						if (fill_q == FILL_LAST) begin
							fill_q  <= '0;
							n_q     <= '0;
							m_q     <= '0;
							k_q     <= '0;
							state_q <= ST_MAC;
						end else begin
							fill_q <= fill_q + 1'b1;
						end
					end
				end
				ST_MAC: begin
					n_q <= n_q + 1'b1;
					m_q <= m_next;
					if (n_q == FILL_LAST) begin
						state_q <= ST_DRAIN;
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !v_s2) begin
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: state_q <= ST_SQA;
				ST_SQA:   state_q <= ST_SQB;
				ST_SQB:   state_q <= ST_SQC;
				ST_SQC:   state_q <= ST_SQRT;
				ST_SQRT: begin
					if (sqrt_stat.done) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_go) begin
						if (k_q == BIN_LAST) begin
							state_q <= ST_COLLECT;
						end else begin
							k_q     <= k_q + 1'b1;
							n_q     <= '0;
							m_q     <= '0;
							state_q <= ST_MAC;
						end
					end
				end
				default: state_q <= ST_COLLECT;
			endcase
		end
	end

	// frame memory
	always_ff @(posedge clk) begin
		if (in_acc) begin
			frame_mem[fill_q] <= sample;
		end
	end

	always_ff @(posedge clk) begin
		samp_s1 <= frame_mem[n_q];
		cos_s1  <= COS_TAB[m_q];
		sin_s1  <= SIN_TAB[m_q];
		pre_s2  <= samp_s1 * cos_s1;
		pim_s2  <= samp_s1 * sin_s1;
	end

	// accumulate and magnitude datapath
	always_ff @(posedge clk) begin
		if (state_q == ST_COLLECT || emit_go) begin
			re_q <= '0;
			im_q <= '0;
		end else if (v_s2) begin
			re_q <= re_q + {{(ACC_W-PROD_W){pre_s2[PROD_W-1]}}, pre_s2};
			im_q <= im_q + {{(ACC_W-PROD_W){pim_s2[PROD_W-1]}}, pim_s2};
		end
		if (state_q == ST_ROUND) begin
			a_q <= rnd_re[ACC_W-1:Q8_SHIFT];
			b_q <= rnd_im[ACC_W-1:Q8_SHIFT];
		end
		if (state_q == ST_SQA || state_q == ST_SQB) begin
			sq_s1 <= sq_op * sq_op;
		end
		if (state_q == ST_SQB) begin
			sum_q <= sq_s1;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit_go) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_go) begin
			bin_index_q <= k_q;
			magnitude_q <= mag_div[MAG_W-1:0];
			last_bin_q  <= (k_q == BIN_LAST);
		end
	end

	assign out_valid = out_valid_q;
	assign bin_index = bin_index_q;
	assign magnitude = magnitude_q;
	assign last_bin  = last_bin_q;

	`DFTMS_ASSERT_IMPL(a_collect_pipe_empty, clk, arst_n, state_q == ST_COLLECT, !v_s1 && !v_s2)
	`DFTMS_ASSERT_IMPL(a_sqrt_done_state, clk, arst_n, sqrt_stat.done, state_q == ST_SQRT)
	`DFTMS_ASSERT_IMPL(a_sqrt_busy_state, clk, arst_n, sqrt_stat.busy, state_q == ST_SQRT)
	`DFTMS_ASSERT_IMPL(a_last_bin_index, clk, arst_n, out_valid_q && last_bin_q, bin_index_q == BIN_LAST)
	`DFTMS_ASSERT_NEXT(a_frame_full_start, clk, arst_n, in_acc && fill_q == FILL_LAST, state_q == ST_MAC && k_q == '0 && n_q == '0)

endmodule

### rtl/dftms_isqrt.sv
// ----------------------------------------------------------------------------
// dftms_isqrt
// iterative floor square root, one result bit per cycle
// ----------------------------------------------------------------------------
module dftms_isqrt (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [dftms_pkg::SQ_W-1:0]  radicand,
	output dftms_pkg::sqrt_stat_t     stat,
	output logic [dftms_pkg::RND_W-1:0] root
);
	import dftms_pkg::*;

	localparam logic [SQ_W-1:0] START_BIT = SQ_W'(1) << (SQ_W - 2);

	logic [SQ_W-1:0] rem_q;
	logic [SQ_W-1:0] res_q;
	logic [SQ_W-1:0] bit_q;
	logic            busy_q;
	logic            done_q;
	logic [SQ_W:0]   trial;
	logic            fits;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign fits  = ({1'b0, rem_q} >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
		end else if (busy_q) begin
			if (bit_q[0]) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= radicand;
			res_q <= '0;
			bit_q <= START_BIT;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - trial[SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign root      = res_q[RND_W-1:0];

endmodule

### test/testbench.sv
// ----------------------------------------------------------------------------
// dft magnitude spectrum testbench
// frames of samples go in through the input channel; a local model of the
// fixed-point twiddle rom, complex accumulation, q8 rounding and square root
// predicts the 64 bin magnitudes of every full frame, and each result item
// is checked field by field against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module testbench;

	import dftms_pkg::*;

	localparam int          STALL_LIMIT  = 4000;
	localparam int          SETTLE_TIME  = POINTS + 80;
	localparam int          EXTREME_CNT  = 25;
	localparam int          RANDOM_CNT   = 39;
	localparam int          TONE_CNT     = 32;
	localparam logic [63:0] POLY_C1      = 64'd1686629713;
	localparam logic [63:0] POLY_C3      = 64'd693598668;
	localparam logic [63:0] POLY_C5      = 64'd85569305;
	localparam logic [63:0] POLY_C7      = 64'd5026995;
	localparam logic [63:0] POLY_C9      = 64'd172272;

	typedef struct {
		logic [BIN_W-1:0] bin_index;
		logic [MAG_W-1:0] magnitude;
		logic             last_bin;
	} spectrum_bin_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       in_valid;
	logic                       in_stall;
	logic signed [SAMPLE_W-1:0] sample;
	logic                       out_valid;
	logic                       out_stall;
	logic [BIN_W-1:0]           bin_index;
	logic [MAG_W-1:0]           magnitude;
	logic                       last_bin;

	longint                     cos_rom [POINTS];
	longint                     sin_rom [POINTS];
	logic signed [SAMPLE_W-1:0] frame_buf [POINTS];
	int                         frame_fill;
	spectrum_bin_t              pending_bins [$];
	int                         mismatch_count;
	int                         idle_cycles;
	bit                         quiet_tail;

	dft_magnitude_spectrum u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.sample    (sample),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.bin_index (bin_index),
		.magnitude (magnitude),
		.last_bin  (last_bin)
	);

	always #5 clk = ~clk;

	// sine over one quadrant, q in 0..16384, q1.15
	function automatic longint quadrant_sin(input int unsigned q);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] t;
		logic [63:0] s;
		x  = 64'(q) << 16;
		x2 = (x * x) >> 30;
		t  = POLY_C9;
		t  = POLY_C7 - ((x2 * t) >> 30);
		t  = POLY_C5 - ((x2 * t) >> 30);
		t  = POLY_C3 - ((x2 * t) >> 30);
		t  = POLY_C1 - ((x2 * t) >> 30);
		s  = (x * t) >> 30;
		s  = (s + 64'd16384) >> 15;
		if (s > 64'd32767) begin
			s = 64'd32767;
		end
		return longint'(s);
	endfunction

	function automatic longint phase_sin(input logic [15:0] phase);
		longint v;
		if (phase[14]) begin
			v = quadrant_sin(32'd16384 - 32'(phase[13:0]));
		end else begin
			v = quadrant_sin(32'(phase[13:0]));
		end
		return phase[15] ? -v : v;
	endfunction

	function automatic longint unsigned floor_sqrt(input longint unsigned v);
		longint unsigned rest;
		longint unsigned root;
		longint unsigned probe;
		rest  = v;
		root  = 0;
		probe = 64'd1 << 62;
		while (probe > rest) begin
			probe = probe >> 2;
		end
		while (probe != 0) begin
			if (rest >= root + probe) begin
				rest = rest - (root + probe);
				root = (root >> 1) + probe;
			end else begin
				root = root >> 1;
			end
			probe = probe >> 2;
		end
		return root;
	endfunction

	function automatic longint unsigned q8_abs(input longint a);
		longint unsigned m;
		m = (a < 0) ? longint'(-a) : longint'(a);
		return (m + 64) >> 7;
	endfunction

	function automatic void build_twiddle_rom();
		logic [15:0] phase;
		for (int m = 0; m < POINTS; m++) begin
			phase      = 16'((64'(2 * m) * 64'd65536 + 64'(POINTS)) / 64'(2 * POINTS));
			sin_rom[m] = phase_sin(phase);
			cos_rom[m] = phase_sin(phase + 16'd16384);
		end
	endfunction

	// direct dft of the stored frame, one expected item per bin
	function automatic void predict_spectrum();
		longint          re;
		longint          im;
		longint unsigned a;
		longint unsigned b;
		longint unsigned root;
		int              m;
		spectrum_bin_t   item;
		for (int k = 0; k < HALF; k++) begin
			re = 0;
			im = 0;
			for (int n = 0; n < POINTS; n++) begin
				m  = (k * n) % POINTS;
				re += longint'(frame_buf[n]) * cos_rom[m];
				im += longint'(frame_buf[n]) * sin_rom[m];
			end
			a              = q8_abs(re);
			b              = q8_abs(im);
			root           = floor_sqrt(a * a + b * b);
			root           = (root + POINTS / 2) / POINTS;
			item.bin_index = BIN_W'(k);
			item.magnitude = root[MAG_W-1:0];
			item.last_bin  = (k == HALF - 1);
			pending_bins   = {pending_bins, item};
		end
	endfunction

	always @(posedge clk) begin
		spectrum_bin_t want;
		bit            moved;
		if (arst_n) begin
			moved = 1'b0;
			if (in_valid && !in_stall) begin
				moved                 = 1'b1;
				frame_buf[frame_fill] = sample;
				frame_fill++;
				if (frame_fill == POINTS) begin
					frame_fill = 0;
					predict_spectrum();
				end
			end
			if (out_valid && !out_stall) begin
				moved = 1'b1;
				if (pending_bins.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("unexpected item: bin %0d magnitude %0d last %0b",
							bin_index, magnitude, last_bin);
					end
				end else begin
					want = pending_bins.pop_front();
					if (bin_index !== want.bin_index || magnitude !== want.magnitude ||
						last_bin !== want.last_bin) begin
						mismatch_count++;
						if (mismatch_count <= 10) begin
							$display("mismatch: want %0d %0d %0b, got %0d %0d %0b",
								want.bin_index, want.magnitude, want.last_bin,
								bin_index, magnitude, last_bin);
						end
					end
				end
			end
			idle_cycles = moved ? 0 : idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("simulation failed");
				$finish;
			end
		end
	end

	// receiver stall bursts
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (!quiet_tail && $urandom_range(0, 5) == 0) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 9)) @(negedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	task automatic push_sample(input logic signed [SAMPLE_W-1:0] v);
		int gap;
		if (!quiet_tail && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid <= 1'b1;
		sample   <= v;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic wait_spectrum_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
	endtask

	task automatic test_sample_extremes();
		logic signed [SAMPLE_W-1:0] edge_vals [EXTREME_CNT];
		edge_vals = '{16'sh8000, 16'sh7fff, 16'sh0000, 16'shffff, 16'sh0001,
			16'sh5555, 16'shaaaa, 16'sh7ffe, 16'sh8001, 16'sh00ff,
			16'shff00, 16'sh4000, 16'shc000, 16'sh0080, 16'shff80,
			16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh8000, 16'sh0f0f,
			16'shf0f0, 16'sh3fff, 16'shc001, 16'sh0002, 16'shfffe};
		foreach (edge_vals[i]) begin
			push_sample(edge_vals[i]);
		end
	endtask

	// part of the first frame: full range and small values mixed
	task automatic test_random_frame(input int count);
		logic signed [SAMPLE_W-1:0] v;
		repeat (count) begin
			if ($urandom_range(0, 2) == 0) begin
				v = SAMPLE_W'($signed($urandom_range(0, 511)) - 256);
			end else begin
				v = SAMPLE_W'($urandom_range(0, 65535));
			end
			push_sample(v);
		end
	endtask

	// sinusoid at a random bin with random amplitude, phase and noise
	task automatic test_tone_frame(input int count);
		real amp;
		real phase0;
		real val;
		int  tone_bin;
		int  noise;
		int  s;
		tone_bin = $urandom_range(0, HALF - 1);
		amp      = real'($urandom_range(0, 32767));
		phase0   = real'($urandom_range(0, 999)) / 1000.0 * 6.283185307179586;
		noise    = $urandom_range(0, 300);
		for (int n = 0; n < count; n++) begin
			val = amp * $cos(6.283185307179586 * tone_bin * n / POINTS + phase0);
			s   = $rtoi(val) + $signed($urandom_range(0, 2 * noise)) - noise;
			if (s > 32767) begin
				s = 32767;
			end else if (s < -32768) begin
				s = -32768;
			end
			push_sample(SAMPLE_W'(s));
		end
	endtask

	// full-scale square wave of random period, a long period giving dc
	task automatic test_square_frame(input int count);
		int period;
		bit level;
		period = $urandom_range(1, 200);
		level  = $urandom_range(0, 1);
		for (int n = 0; n < count; n++) begin
			if (n != 0 && n % period == 0) begin
				level = ~level;
			end
			push_sample(level ? 16'sh7fff : 16'sh8000);
		end
	endtask

	task automatic test_partial_frame();
		repeat ($urandom_range(15, 30)) begin
			push_sample(SAMPLE_W'($urandom_range(0, 65535)));
		end
	endtask

	initial begin
		arst_n         = 1'b0;
		in_valid       = 1'b0;
		sample         = '0;
		frame_fill     = 0;
		mismatch_count = 0;
		idle_cycles    = 0;
		quiet_tail     = 1'b0;
		build_twiddle_rom();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_sample_extremes();
		test_random_frame(RANDOM_CNT);
		test_tone_frame(TONE_CNT);
		test_square_frame(POINTS - EXTREME_CNT - RANDOM_CNT - TONE_CNT);
		wait_spectrum_drained();
		quiet_tail = 1'b1;
		test_partial_frame();

		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_bins.size() != 0) @(posedge clk);
		repeat (SETTLE_TIME) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
